### design/cig_pkg.sv
`default_nettype none

package cig_pkg;

  // Field and register widths
  localparam int DIM_W    = 9;
  localparam int KDIM_W   = 4;
  localparam int COORD_W  = 8;
  localparam int SRC_W    = 24;
  localparam int DST_W    = 24;
  localparam int FLT_W    = 22;
  localparam int MULB_W   = 9;
  localparam int CFG_IDX_W = 3;

  // At most this many results leave for one item
  localparam int RESULT_LIMIT = 64;
  localparam int CNT_W        = $clog2(RESULT_LIMIT);

  // Restoring division takes one quotient bit per cycle
  localparam int DIV_STEPS = DIM_W;
  localparam int DIVC_W    = $clog2(DIV_STEPS);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_WIDTH    = 3'd0,
    REG_INPUT_HEIGHT   = 3'd1,
    REG_IN_CHANS       = 3'd2,
    REG_KERN_W         = 3'd3,
    REG_KERN_H         = 3'd4,
    REG_FILT_COUNT     = 3'd5,
    REG_STRIDE_WIDTH   = 3'd6,
    REG_STRIDE_HEIGHT  = 3'd7
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_W,
    ST_DIV_H,
    ST_CHECK,
    ST_DEST0,
    ST_DEST1,
    ST_Y0,
    ST_ROW,
    ST_X0,
    ST_SRC,
    ST_STEP,
    ST_FILT,
    ST_EMIT
  } state_t;

  // A zero register reads as one; a value above the limit reads as the limit.
  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > hi) begin
      r = hi[DIM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [KDIM_W-1:0] clamp_kdim(logic [KDIM_W-1:0] v, int unsigned hi);
    logic [KDIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = KDIM_W'(1);
    end else if (32'(v) > hi) begin
      r = hi[KDIM_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/conv2d_connection_index_generator.sv
// Flow: an accepted item is checked, then takes eight steps on the shared multiply-add unit,
// then gives one result per cycle, kernel height times kernel width results in all, and holds
// the block until its last tap. The first item after a configuration write first runs the two
// output-size divisions (one quotient bit a cycle). An out-of-range item gives just its one
// error result. Reset (synchronous, rst_n low) sets every configuration register to 1 and
// idles; the receiver cannot stall.
`default_nettype none

module conv2d_connection_index_generator #(
  parameter int unsigned MAX_KERNEL_DIM  = 8,
  parameter int unsigned MAX_FEATURE_DIM = 256,
  parameter int unsigned MAX_CHANNELS    = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Command channel
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [cig_pkg::COORD_W-1:0]         in_out_channel,
  input  wire logic [cig_pkg::COORD_W-1:0]         in_out_row,
  input  wire logic [cig_pkg::COORD_W-1:0]         in_out_col,
  input  wire logic [cig_pkg::COORD_W-1:0]         in_in_channel,
  // Result channel
  output logic                                     out_valid,
  output logic [cig_pkg::SRC_W-1:0]                out_src_idx,
  output logic [cig_pkg::DST_W-1:0]                out_dst_idx,
  output logic [cig_pkg::FLT_W-1:0]                out_filter_index,
  output logic                                     out_coord_error,
  output logic                                     out_last,
  // Configuration channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [cig_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [cig_pkg::DIM_W-1:0]           cfg_data
);

  localparam int DIM_W  = cig_pkg::DIM_W;
  localparam int KDIM_W = cig_pkg::KDIM_W;
  localparam int SRC_W  = cig_pkg::SRC_W;
  localparam int FLT_W  = cig_pkg::FLT_W;
  localparam int MULB_W = cig_pkg::MULB_W;
  localparam int PROD_W = SRC_W + MULB_W;

  // Configuration registers
  logic [DIM_W-1:0]  input_width_r, input_height_r, in_chans_r, filt_count_r;
  logic [KDIM_W-1:0] kern_w_r, kern_h_r, stride_width_r, stride_height_r;
  logic              cfg_beat;

  // A command offered in the same cycle goes first, so a write never meets an accept.
  assign cfg_ready = ~busy & ~start;
  assign cfg_beat  = cfg_valid & cfg_ready;

  // Register writes; a beat to any register also marks the output sizes stale.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_width_r    <= DIM_W'(1);
      input_height_r   <= DIM_W'(1);
      in_chans_r       <= DIM_W'(1);
      kern_w_r         <= KDIM_W'(1);
      kern_h_r         <= KDIM_W'(1);
      filt_count_r     <= DIM_W'(1);
      stride_width_r   <= KDIM_W'(1);
      stride_height_r  <= KDIM_W'(1);
    end else if (cfg_beat) begin
      unique case (cig_pkg::reg_idx_t'(cfg_index))
        cig_pkg::REG_INPUT_WIDTH:    input_width_r    <= cfg_data;
        cig_pkg::REG_INPUT_HEIGHT:   input_height_r   <= cfg_data;
        cig_pkg::REG_IN_CHANS:       in_chans_r       <= cfg_data;
        cig_pkg::REG_KERN_W:         kern_w_r         <= cfg_data[KDIM_W-1:0];
        cig_pkg::REG_KERN_H:         kern_h_r         <= cfg_data[KDIM_W-1:0];
        cig_pkg::REG_FILT_COUNT:     filt_count_r     <= cfg_data;
        cig_pkg::REG_STRIDE_WIDTH:   stride_width_r   <= cfg_data[KDIM_W-1:0];
        cig_pkg::REG_STRIDE_HEIGHT:  stride_height_r  <= cfg_data[KDIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective (clamped) register values
  logic [DIM_W-1:0]  iw_c, ih_c, ic_c, kc_c;
  logic [KDIM_W-1:0] kw_c, kh_c, sw_c, sh_c;

  assign iw_c = cig_pkg::clamp_dim(input_width_r, MAX_FEATURE_DIM);
  assign ih_c = cig_pkg::clamp_dim(input_height_r, MAX_FEATURE_DIM);
  assign ic_c = cig_pkg::clamp_dim(in_chans_r, MAX_CHANNELS);
  assign kc_c = cig_pkg::clamp_dim(filt_count_r, MAX_CHANNELS);
  assign kw_c = cig_pkg::clamp_kdim(kern_w_r, MAX_KERNEL_DIM);
  assign kh_c = cig_pkg::clamp_kdim(kern_h_r, MAX_KERNEL_DIM);
  assign sw_c = cig_pkg::clamp_kdim(stride_width_r, MAX_KERNEL_DIM);
  assign sh_c = cig_pkg::clamp_kdim(stride_height_r, MAX_KERNEL_DIM);

  // Sequencer
  cig_pkg::state_t state_r, state_nxt;
  logic            dims_ok_r;
  logic            div_done;
  logic            coord_bad;
  logic            last_tap;
  logic            accept;

  assign busy   = (state_r != cig_pkg::ST_IDLE);
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cig_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cig_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = dims_ok_r ? cig_pkg::ST_CHECK : cig_pkg::ST_DIV_W;
        end
      end
      cig_pkg::ST_DIV_W: if (div_done) state_nxt = cig_pkg::ST_DIV_H;
      cig_pkg::ST_DIV_H: if (div_done) state_nxt = cig_pkg::ST_CHECK;
      cig_pkg::ST_CHECK: state_nxt = coord_bad ? cig_pkg::ST_IDLE : cig_pkg::ST_DEST0;
      cig_pkg::ST_DEST0: state_nxt = cig_pkg::ST_DEST1;
      cig_pkg::ST_DEST1: state_nxt = cig_pkg::ST_Y0;
      cig_pkg::ST_Y0:    state_nxt = cig_pkg::ST_ROW;
      cig_pkg::ST_ROW:   state_nxt = cig_pkg::ST_X0;
      cig_pkg::ST_X0:    state_nxt = cig_pkg::ST_SRC;
      cig_pkg::ST_SRC:   state_nxt = cig_pkg::ST_STEP;
      cig_pkg::ST_STEP:  state_nxt = cig_pkg::ST_FILT;
      cig_pkg::ST_FILT:  state_nxt = cig_pkg::ST_EMIT;
      cig_pkg::ST_EMIT:  if (last_tap) state_nxt = cig_pkg::ST_IDLE;
      default:           state_nxt = cig_pkg::ST_IDLE;
    endcase
  end

  // Item capture
  logic [cig_pkg::COORD_W-1:0] oc_r, orow_r, ocol_r, cin_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      oc_r   <= in_out_channel;
      orow_r <= in_out_row;
      ocol_r <= in_out_col;
      cin_r  <= in_in_channel;
    end
  end

  // Output-size divider: (in - kernel) / stride, one quotient bit a cycle
  logic [DIM_W-1:0]          quo_r, quo_nxt;
  logic [KDIM_W-1:0]         rem_r, rem_nxt;
  logic [cig_pkg::DIVC_W-1:0] div_cnt_r;
  logic [KDIM_W:0]           trial;
  logic [KDIM_W-1:0]         divisor;
  logic                      trial_ge;
  logic [DIM_W-1:0]          ow_r, oh_r;
  logic                      kw_big, kh_big;
  logic [DIM_W-1:0]          size_q;

  assign divisor  = (state_r == cig_pkg::ST_DIV_H) ? sh_c : sw_c;
  assign trial    = {rem_r, quo_r[DIM_W-1]};
  assign trial_ge = (trial >= {1'b0, divisor});
  assign rem_nxt  = trial_ge ? KDIM_W'(trial - {1'b0, divisor}) : trial[KDIM_W-1:0];
  assign quo_nxt  = {quo_r[DIM_W-2:0], trial_ge};
  assign div_done = (div_cnt_r == cig_pkg::DIVC_W'(cig_pkg::DIV_STEPS - 1));
  assign kw_big   = (DIM_W'(kw_c) > iw_c);
  assign kh_big   = (DIM_W'(kh_c) > ih_c);
  assign size_q   = quo_nxt + DIM_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_ok_r <= 1'b0;
    end else if (cfg_beat) begin
      dims_ok_r <= 1'b0;
    end else if (state_r == cig_pkg::ST_DIV_H && div_done) begin
      dims_ok_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      quo_r     <= iw_c - DIM_W'(kw_c);
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (state_r == cig_pkg::ST_DIV_W || state_r == cig_pkg::ST_DIV_H) begin
      if (div_done) begin
        // Reload for the height division after the width one
        quo_r     <= ih_c - DIM_W'(kh_c);
        rem_r     <= '0;
        div_cnt_r <= '0;
        if (state_r == cig_pkg::ST_DIV_W) begin
          ow_r <= kw_big ? '0 : size_q;
        end else begin
          oh_r <= kh_big ? '0 : size_q;
        end
      end else begin
        quo_r     <= quo_nxt;
        rem_r     <= rem_nxt;
        div_cnt_r <= div_cnt_r + cig_pkg::DIVC_W'(1);
      end
    end
  end

  // Coordinate range check
  assign coord_bad = (DIM_W'(oc_r) >= kc_c) || (DIM_W'(orow_r) >= oh_r) ||
                     (DIM_W'(ocol_r) >= ow_r) || (DIM_W'(cin_r) >= ic_c);

  // Shared multiply-add unit: y = a * b + c, operands chosen by the sequencer
  logic [SRC_W-1:0]  mac_a, mac_c, mac_y;
  logic [MULB_W-1:0] mac_b;
  logic [PROD_W-1:0] mac_prod;
  logic [SRC_W-1:0]  acc_r, x0_r, dest_r, src_r;
  logic [FLT_W-1:0]  step_r, filt_r;

  always_comb begin
    mac_a = '0;
    mac_b = '0;
    mac_c = '0;
    unique case (state_r)
      cig_pkg::ST_DEST0: begin
        mac_a = SRC_W'(oc_r);   mac_b = oh_r;                 mac_c = SRC_W'(orow_r);
      end
      cig_pkg::ST_DEST1: begin
        mac_a = acc_r;          mac_b = ow_r;                 mac_c = SRC_W'(ocol_r);
      end
      cig_pkg::ST_Y0: begin
        mac_a = SRC_W'(orow_r); mac_b = MULB_W'(sh_c);
      end
      cig_pkg::ST_ROW: begin
        mac_a = SRC_W'(cin_r);  mac_b = ih_c;                 mac_c = acc_r;
      end
      cig_pkg::ST_X0: begin
        mac_a = SRC_W'(ocol_r); mac_b = MULB_W'(sw_c);
      end
      cig_pkg::ST_SRC: begin
        mac_a = acc_r;          mac_b = iw_c;                 mac_c = x0_r;
      end
      cig_pkg::ST_STEP: begin
        mac_a = SRC_W'(ic_c);   mac_b = kc_c;
      end
      cig_pkg::ST_FILT: begin
        mac_a = SRC_W'(cin_r);  mac_b = kc_c;                 mac_c = SRC_W'(oc_r);
      end
      default: ;
    endcase
  end

  assign mac_prod = PROD_W'(mac_a) * PROD_W'(mac_b);
  assign mac_y    = mac_prod[SRC_W-1:0] + mac_c;

  // Tap walk: source steps by one along a kernel row and jumps to the next input row
  // at its end; the filter index advances by input channels * filter count per tap.
  logic [KDIM_W-1:0]        kx_r, ky_r;
  logic [cig_pkg::CNT_W-1:0] cnt_r;
  logic                     row_end;
  logic [SRC_W-1:0]         row_skip;

  assign row_end  = (kx_r == kw_c - KDIM_W'(1));
  assign last_tap = (row_end && (ky_r == kh_c - KDIM_W'(1))) ||
                    (cnt_r == cig_pkg::CNT_W'(cig_pkg::RESULT_LIMIT - 1));
  assign row_skip = SRC_W'(iw_c) - SRC_W'(kw_c) + SRC_W'(1);

  always_ff @(posedge clk) begin
    unique case (state_r)
      cig_pkg::ST_DEST0, cig_pkg::ST_Y0, cig_pkg::ST_ROW: acc_r <= mac_y;
      cig_pkg::ST_DEST1: dest_r <= mac_y;
      cig_pkg::ST_X0:    x0_r   <= mac_y;
      cig_pkg::ST_SRC:   src_r  <= mac_y;
      cig_pkg::ST_STEP:  step_r <= mac_y[FLT_W-1:0];
      cig_pkg::ST_FILT: begin
        filt_r <= mac_y[FLT_W-1:0];
        kx_r   <= '0;
        ky_r   <= '0;
        cnt_r  <= '0;
      end
      cig_pkg::ST_EMIT: begin
        src_r  <= src_r + (row_end ? row_skip : SRC_W'(1));
        filt_r <= filt_r + step_r;
        cnt_r  <= cnt_r + cig_pkg::CNT_W'(1);
        if (row_end) begin
          kx_r <= '0;
          ky_r <= ky_r + KDIM_W'(1);
        end else begin
          kx_r <= kx_r + KDIM_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Result register: one beat per cycle while taps are walked, or a single error beat
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == cig_pkg::ST_EMIT) ||
                     (state_r == cig_pkg::ST_CHECK && coord_bad);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == cig_pkg::ST_EMIT) begin
      out_src_idx      <= src_r;
      out_dst_idx      <= dest_r;
      out_filter_index <= filt_r;
      out_coord_error  <= 1'b0;
      out_last         <= last_tap;
    end else if (state_r == cig_pkg::ST_CHECK) begin
      out_src_idx      <= '0;
      out_dst_idx      <= '0;
      out_filter_index <= '0;
      out_coord_error  <= 1'b1;
      out_last         <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  // Checks
  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("result without last while the sequencer is idle");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not occupy the block");

  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_coord_error |-> out_last && out_src_idx == '0 &&
      out_dst_idx == '0 && out_filter_index == '0)
    else $error("coordinate error beat is malformed");

  a_tap_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cig_pkg::ST_EMIT |-> kx_r < kw_c && ky_r < kh_c)
    else $error("tap counters left the kernel");

endmodule

`default_nettype wire
